// File: rtl/core/a85_pkg.sv
// ----------------------------------------------------------------------------
// a85_pkg: shared types and constants of the ASCII85 line encoder
// Character codes, divider constants and the job records passed between the
// front end, the digit converter and the character emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package a85_pkg;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_BANG  = 8'd33;
    localparam logic [7:0] CH_PCT   = 8'd37;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_Z     = 8'd122;
    localparam logic [7:0] CH_TILDE = 8'd126;

    // digit values (character minus '!')
    localparam logic [6:0] DIG_BANG = 7'd0;
    localparam logic [6:0] DIG_PCT  = 7'd4;

    localparam logic [7:0] LIMIT_RESET = 8'd79;

    // floor(w / 85) == (w * DIV_MAGIC) >> DIV_SHIFT for any 32-bit w
    localparam logic [31:0] DIV_MAGIC = 32'hC0C0C0C1;
    localparam int          DIV_SHIFT = 38;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [4:0][6:0] digits_t;

    typedef struct packed {
        logic        is_flush;
        logic        run_end;
        logic [1:0]  fill;
        logic [31:0] word;
    } job_t;

    typedef struct packed {
        logic        is_flush;
        logic        run_end;
        logic [1:0]  fill;
        logic        is_zero;
        digits_t     digit;
    } conv_t;

endpackage

`default_nettype wire

// File: rtl/core/a85_if.sv
// ----------------------------------------------------------------------------
// a85_if: channel interfaces of the ASCII85 line encoder
// Input byte channel, output character channel and line limit write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface a85_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;
    modport source (output valid, data_byte, byte_present, is_last, input ready);
    modport sink (input valid, data_byte, byte_present, is_last, output ready);
endinterface

interface a85_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;
    modport source (output valid, out_char, run_end, input ready);
    modport sink (input valid, out_char, run_end, output ready);
endinterface

interface a85_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] col_limit;
    modport source (output valid, col_limit, input ready);
    modport sink (input valid, col_limit, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ascii85_line_encoder.sv
// ----------------------------------------------------------------------------
// ascii85_line_encoder: ASCII85 encoder with line breaking
// Encodes a byte stream into ASCII85 characters with line length limit,
// percent-at-line-start protection and stream terminator.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  items    in   valid/ready   data_byte, byte_present, is_last
//  chars    out  valid/ready   out_char, run_end
//  cfg      in   valid/ready   col_limit (always ready)
//
//  Bytes are taken one per cycle while the queue has room and no flush is
//  held; a full group or a flush is queued and converted by a shared
//  divide-by-85 unit, each division a multiply step then a remainder step.
//  Characters leave at one per cycle while the output is ready; each job
//  also passes setup, the line break check and the percent or space check.
//  Reset clears the group, line column, previous character (newline) and sets
//  the column limit to 79. Output stalls back up through emitter, converter
//  and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii85_line_encoder #(
    parameter int QUEUE_DEPTH = a85_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    a85_item_if.sink    items,
    a85_char_if.source  chars,
    a85_cfg_if.sink     cfg
);
    import a85_pkg::*;

    logic [7:0] limit_reg;
    job_t       push_job;
    logic       push_valid;
    logic       push_ready;
    job_t       pop_job;
    logic       pop_valid;
    logic       pop_ready;
    conv_t      conv;
    logic       conv_valid;
    logic       conv_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg.valid)
            limit_reg <= cfg.col_limit;
    end

    a85_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    a85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    a85_digits u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (pop_job),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .conv       (conv),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready)
    );

    a85_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .col_limit  (limit_reg),
        .conv       (conv),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .chars      (chars)
    );

endmodule

`default_nettype wire

// File: rtl/core/a85_front.sv
// ----------------------------------------------------------------------------
// a85_front: byte grouping front end
// Gathers bytes into groups of four and turns full groups and stream ends
// into jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module a85_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    a85_item_if.sink           items,
    output a85_pkg::job_t      push_job,
    output logic               push_valid,
    input  wire logic          push_ready
);
    import a85_pkg::*;

    logic [23:0] group_reg, group_next;
    logic [1:0]  fill_reg, fill_next;
    logic        hold_valid_reg, hold_valid_next;
    job_t        hold_reg, hold_next;

    logic        accept;
    logic        full;
    logic [1:0]  fill_after;
    logic [23:0] bytes_after;
    job_t        group_job;
    job_t        flush_job;

    assign items.ready = !hold_valid_reg && push_ready;
    assign accept      = items.valid && items.ready;
    assign full        = items.byte_present && (fill_reg == 2'd3);

    always_comb
    begin
        if (full)
        begin
            fill_after  = 2'd0;
            bytes_after = 24'd0;
        end
        else if (items.byte_present)
        begin
            fill_after  = fill_reg + 2'd1;
            bytes_after = {group_reg[15:0], items.data_byte};
        end
        else
        begin
            fill_after  = fill_reg;
            bytes_after = group_reg;
        end

        group_job.is_flush = 1'b0;
        group_job.run_end  = !items.is_last;
        group_job.fill     = 2'd0;
        group_job.word     = {group_reg, items.data_byte};

        flush_job.is_flush = 1'b1;
        flush_job.run_end  = 1'b1;
        flush_job.fill     = fill_after;
        case (fill_after)
            2'd1:    flush_job.word = {bytes_after[7:0], 24'd0};
            2'd2:    flush_job.word = {bytes_after[15:0], 16'd0};
            2'd3:    flush_job.word = {bytes_after, 8'd0};
            default: flush_job.word = 32'd0;
        endcase
    end

    always_comb
    begin
        group_next      = group_reg;
        fill_next       = fill_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        push_valid      = 1'b0;
        push_job        = hold_reg;

        if (hold_valid_reg)
        begin
            push_valid = 1'b1;
            if (push_ready)
                hold_valid_next = 1'b0;
        end
        else if (accept)
        begin
            if (items.is_last)
            begin
                group_next = 24'd0;
                fill_next  = 2'd0;
            end
            else
            begin
                group_next = bytes_after;
                fill_next  = fill_after;
            end

            if (full)
            begin
                push_valid = 1'b1;
                push_job   = group_job;
                // hold the flush behind the group
                if (items.is_last)
                begin
                    hold_valid_next = 1'b1;
                    hold_next       = flush_job;
                end
            end
            else if (items.is_last)
            begin
                push_valid = 1'b1;
                push_job   = flush_job;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg      <= 24'd0;
            fill_reg       <= 2'd0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            group_reg      <= group_next;
            fill_reg       <= fill_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/a85_queue.sv
// ----------------------------------------------------------------------------
// a85_queue: job queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module a85_queue #(
    parameter int DEPTH = a85_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire a85_pkg::job_t push_job,
    input  wire logic          push_valid,
    output logic               push_ready,
    output a85_pkg::job_t      pop_job,
    output logic               pop_valid,
    input  wire logic          pop_ready
);
    import a85_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// File: rtl/core/a85_digits.sv
// ----------------------------------------------------------------------------
// a85_digits: base-85 digit converter
// Splits a 32-bit word into five base-85 digits by reciprocal multiply, each
// division a multiply step then a remainder step; takes a new job once idle.
// ----------------------------------------------------------------------------
`default_nettype none

module a85_digits (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire a85_pkg::job_t job,
    input  wire logic          job_valid,
    output logic               job_ready,
    output a85_pkg::conv_t     conv,
    output logic               conv_valid,
    input  wire logic          conv_ready
);
    import a85_pkg::*;

    logic        busy_reg;
    logic        phase_reg;
    logic [1:0]  cnt_reg;
    logic [31:0] w_reg;
    logic [63:0] prod_reg;
    digits_t     dig_reg;
    logic        is_flush_reg;
    logic        run_end_reg;
    logic [1:0]  fill_reg;
    logic        is_zero_reg;
    logic        out_valid_reg;
    conv_t       out_reg;

    logic [25:0] quo;
    logic [31:0] quo_x;
    logic [31:0] rem_x;
    logic [6:0]  rem;
    logic        slot_free;
    logic        finish;

    assign job_ready  = !busy_reg;
    assign conv       = out_reg;
    assign conv_valid = out_valid_reg;
    assign slot_free  = !out_valid_reg || conv_ready;

    assign quo    = prod_reg[63:DIV_SHIFT];
    assign quo_x  = {6'd0, quo};
    // w - 85*q with 85 = 64 + 16 + 4 + 1
    assign rem_x  = w_reg - ((quo_x << 6) + (quo_x << 4) + (quo_x << 2) + quo_x);
    assign rem    = rem_x[6:0];
    assign finish = busy_reg && phase_reg && (cnt_reg == 2'd3) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg)
            begin
                if (job_valid)
                begin
                    busy_reg  <= 1'b1;
                    phase_reg <= 1'b0;
                    cnt_reg   <= 2'd0;
                end
            end
            else if (!phase_reg)
                phase_reg <= 1'b1;
            else if (cnt_reg != 2'd3)
            begin
                phase_reg <= 1'b0;
                cnt_reg   <= cnt_reg + 2'd1;
            end
            else if (slot_free)
                busy_reg <= 1'b0;

            if (finish)
                out_valid_reg <= 1'b1;
            else if (conv_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && job_valid)
        begin
            w_reg        <= job.word;
            is_flush_reg <= job.is_flush;
            run_end_reg  <= job.run_end;
            fill_reg     <= job.fill;
            is_zero_reg  <= (job.word == 32'd0);
        end
        else if (busy_reg && !phase_reg)
            prod_reg <= {32'd0, w_reg} * {32'd0, DIV_MAGIC};
        else if (busy_reg && phase_reg && cnt_reg != 2'd3)
        begin
            w_reg                  <= quo_x;
            dig_reg[3'd4 - {1'b0, cnt_reg}] <= rem;
        end

        if (finish)
        begin
            out_reg.is_flush <= is_flush_reg;
            out_reg.run_end  <= run_end_reg;
            out_reg.fill     <= fill_reg;
            out_reg.is_zero  <= is_zero_reg;
            out_reg.digit    <= {dig_reg[4], dig_reg[3], dig_reg[2], rem, quo[6:0]};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/a85_emit.sv
// ----------------------------------------------------------------------------
// a85_emit: character emitter
// Sequences digits, 'z', line breaks, flush space and terminator, tracking
// the line column and previous character, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module a85_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     col_limit,
    input  wire a85_pkg::conv_t conv,
    input  wire logic           conv_valid,
    output logic                conv_ready,
    a85_char_if.source          chars
);
    import a85_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BRK  = 4'd1;
    localparam logic [3:0] S_PCT  = 4'd2;
    localparam logic [3:0] S_DIG  = 4'd3;
    localparam logic [3:0] S_DNL  = 4'd4;
    localparam logic [3:0] S_Z    = 4'd5;
    localparam logic [3:0] S_SP   = 4'd6;
    localparam logic [3:0] S_TIL  = 4'd7;
    localparam logic [3:0] S_GT   = 4'd8;

    logic [3:0] state_reg, state_next;
    conv_t      job_reg;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] extra_reg, extra_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] prev_reg, prev_next;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_end_reg;

    logic       step;
    logic       emit;
    logic [7:0] emit_char;
    logic       emit_end;
    logic       stream_done;
    logic [6:0] d0, d1, d2, d3, d4;
    logic [6:0] dsel;
    logic [2:0] last_idx;
    logic [2:0] nchars;
    logic [8:0] flush_len;
    logic       sp_now;
    logic       pct_cond;
    logic [7:0] prev_after;

    assign d0   = job_reg.digit[0];
    assign d1   = job_reg.digit[1];
    assign d2   = job_reg.digit[2];
    assign d3   = job_reg.digit[3];
    assign d4   = job_reg.digit[4];
    assign dsel = job_reg.digit[idx_reg];

    assign step       = !out_valid_reg || chars.ready;
    assign conv_ready = (state_reg == S_IDLE);
    assign last_idx   = job_reg.is_flush ? {1'b0, job_reg.fill} : 3'd4;
    assign nchars     = (job_reg.fill == 2'd0) ? 3'd2 : {1'b0, job_reg.fill} + 3'd3;
    assign sp_now     = (job_reg.fill != 2'd0) && (d0 == DIG_PCT)
                        && (((prev_reg == CH_NL) && (d1 == DIG_PCT || d1 == DIG_BANG))
                            || ((prev_reg == CH_PCT) && (col_reg == 8'd1)));
    assign flush_len  = {1'b0, col_reg} + {6'd0, nchars} + {8'd0, sp_now};
    assign pct_cond   = (d0 == DIG_PCT || d0 == DIG_BANG) && (prev_reg == CH_PCT)
                        && (col_reg == 8'd1);
    assign prev_after = pct_cond ? CH_NL : prev_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        extra_next  = extra_reg;
        emit        = 1'b0;
        emit_char   = CH_NL;
        emit_end    = 1'b0;
        stream_done = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (conv_valid)
                    state_next = S_BRK;
            end
            S_BRK:
            begin
                if (job_reg.is_flush)
                begin
                    emit       = (flush_len > {1'b0, col_limit});
                    state_next = S_SP;
                end
                else if (job_reg.is_zero)
                begin
                    emit       = (col_reg >= col_limit);
                    state_next = S_Z;
                end
                else
                begin
                    emit       = ({1'b0, col_reg} + 9'd5 > {1'b0, col_limit});
                    state_next = S_PCT;
                end
            end
            S_PCT:
            begin
                emit       = pct_cond;
                idx_next   = 3'd0;
                extra_next = 3'd0;
                if (d0 == DIG_PCT && prev_after == CH_NL && (d1 == DIG_PCT || d1 == DIG_BANG))
                begin
                    if (d1 == DIG_BANG)      extra_next = 3'd1;
                    else if (d2 == DIG_BANG) extra_next = 3'd2;
                    else if (d2 != DIG_PCT)  extra_next = 3'd1;
                    else if (d3 == DIG_BANG) extra_next = 3'd3;
                    else if (d3 != DIG_PCT)  extra_next = 3'd2;
                    else if (d4 == DIG_BANG) extra_next = 3'd4;
                    else if (d4 != DIG_PCT)  extra_next = 3'd3;
                    else                     extra_next = 3'd4;
                end
                state_next = S_DIG;
            end
            S_DIG:
            begin
                emit      = 1'b1;
                emit_char = {1'b0, dsel} + CH_BANG;
                if (idx_reg < extra_reg)
                    state_next = S_DNL;
                else if (idx_reg == last_idx)
                begin
                    if (job_reg.is_flush)
                        state_next = S_TIL;
                    else
                    begin
                        emit_end   = job_reg.run_end;
                        state_next = S_IDLE;
                    end
                end
                else
                    idx_next = idx_reg + 3'd1;
            end
            S_DNL:
            begin
                emit       = 1'b1;
                idx_next   = idx_reg + 3'd1;
                state_next = S_DIG;
            end
            S_Z:
            begin
                emit       = 1'b1;
                emit_char  = CH_Z;
                emit_end   = job_reg.run_end;
                state_next = S_IDLE;
            end
            S_SP:
            begin
                emit       = sp_now;
                emit_char  = CH_SP;
                idx_next   = 3'd0;
                extra_next = 3'd0;
                state_next = (job_reg.fill != 2'd0) ? S_DIG : S_TIL;
            end
            S_TIL:
            begin
                emit       = 1'b1;
                emit_char  = CH_TILDE;
                state_next = S_GT;
            end
            S_GT:
            begin
                emit        = 1'b1;
                emit_char   = CH_GT;
                emit_end    = job_reg.run_end;
                stream_done = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        col_next  = col_reg;
        prev_next = prev_reg;
        if (emit)
        begin
            prev_next = emit_char;
            if (emit_char == CH_NL)
                col_next = 8'd0;
            else if (col_reg != 8'd255)
                col_next = col_reg + 8'd1;
        end
        // return to the start-of-stream state
        if (stream_done)
        begin
            col_next  = 8'd0;
            prev_next = CH_NL;
        end
    end

    assign chars.valid    = out_valid_reg;
    assign chars.out_char = out_char_reg;
    assign chars.run_end  = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 3'd0;
            extra_reg     <= 3'd0;
            col_reg       <= 8'd0;
            prev_reg      <= CH_NL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_IDLE || step)
            begin
                state_reg <= state_next;
                idx_reg   <= idx_next;
                extra_reg <= extra_next;
            end
            if (state_reg != S_IDLE && step)
            begin
                col_reg  <= col_next;
                prev_reg <= prev_next;
            end
            if (step && emit && state_reg != S_IDLE)
                out_valid_reg <= 1'b1;
            else if (chars.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && conv_valid)
            job_reg <= conv;
        if (step && emit && state_reg != S_IDLE)
        begin
            out_char_reg <= emit_char;
            out_end_reg  <= emit_end;
        end
    end

endmodule

`default_nettype wire

// File: sim/a85_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// a85_tb_if: testbench-side notes for the encoder channels
// The channel interfaces come with the RTL; this file holds the line limit
// bounds the testbench needs beside the package.
// ----------------------------------------------------------------------------
`default_nettype none

package a85_tb_pkg;
    localparam logic [7:0] LIMIT_MIN = 8'd8;
    localparam logic [7:0] LIMIT_MAX = 8'd255;
endpackage

`default_nettype wire

// File: sim/tb_ascii85_line_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii85_line_encoder: self-checking bench of the ASCII85 line encoder
// Drives byte items with random gaps, stalls the character channel at random,
// predicts each character from a behavioral encoder and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

class a85_scoreboard;
    logic [7:0] limit;
    logic [23:0] grp;
    int unsigned fill;
    int unsigned column;
    logic [7:0] prev;
    logic [8:0] pending[$];
    int errors;

    function new();
        limit = a85_pkg::LIMIT_RESET;
        errors = 0;
        clear();
    endfunction

    function void clear();
        grp = '0;
        fill = 0;
        column = 0;
        prev = a85_pkg::CH_NL;
    endfunction

    function void put(logic [7:0] c);
        pending.push_back({1'b0, c});
        prev = c;
        if (c == a85_pkg::CH_NL)
            column = 0;
        else if (column < 255)
            column++;
    endfunction

    function void split85(logic [31:0] w, output logic [7:0] d[5]);
        for (int i = 4; i >= 0; i--)
        begin
            d[i] = 8'(w % 85) + a85_pkg::CH_BANG;
            w = w / 85;
        end
    endfunction

    function void put_group(logic [31:0] w);
        logic [7:0] d[5];
        int pct_breaks;
        pct_breaks = 0;
        if (w == 0)
        begin
            if (column >= limit)
                put(a85_pkg::CH_NL);
            put(a85_pkg::CH_Z);
            return;
        end
        split85(w, d);
        if (column + 5 > limit)
            put(a85_pkg::CH_NL);
        if ((d[0] == a85_pkg::CH_PCT || d[0] == a85_pkg::CH_BANG)
            && prev == a85_pkg::CH_PCT && column == 1)
            put(a85_pkg::CH_NL);
        if (d[0] == a85_pkg::CH_PCT && prev == a85_pkg::CH_NL
            && (d[1] == a85_pkg::CH_PCT || d[1] == a85_pkg::CH_BANG))
        begin
            // break after the leading percent run
            if (d[1] == a85_pkg::CH_BANG) pct_breaks = 1;
            else if (d[2] == a85_pkg::CH_BANG) pct_breaks = 2;
            else if (d[2] != a85_pkg::CH_PCT) pct_breaks = 1;
            else if (d[3] == a85_pkg::CH_BANG) pct_breaks = 3;
            else if (d[3] != a85_pkg::CH_PCT) pct_breaks = 2;
            else if (d[4] == a85_pkg::CH_BANG) pct_breaks = 4;
            else if (d[4] != a85_pkg::CH_PCT) pct_breaks = 3;
            else pct_breaks = 4;
        end
        for (int i = 0; i < 5; i++)
        begin
            put(d[i]);
            if (i < pct_breaks)
                put(a85_pkg::CH_NL);
        end
    endfunction

    function bit flush_space(logic [7:0] d[5]);
        if (fill == 0 || d[0] != a85_pkg::CH_PCT)
            return 0;
        if (prev == a85_pkg::CH_NL
            && (d[1] == a85_pkg::CH_PCT || d[1] == a85_pkg::CH_BANG))
            return 1;
        return prev == a85_pkg::CH_PCT && column == 1;
    endfunction

    function void put_flush();
        logic [7:0] d[5];
        int unsigned nchars;
        bit sp;
        for (int i = 0; i < 5; i++)
            d[i] = '0;
        nchars = (fill == 0) ? 2 : fill + 3;
        if (fill != 0)
            split85({8'h00, grp} << (8 * (4 - fill)), d);
        sp = flush_space(d);
        if (column + nchars + sp > limit)
        begin
            put(a85_pkg::CH_NL);
            sp = flush_space(d);
        end
        if (sp)
            put(a85_pkg::CH_SP);
        if (fill != 0)
            for (int i = 0; i <= fill; i++)
                put(d[i]);
        put(a85_pkg::CH_TILDE);
        put(a85_pkg::CH_GT);
    endfunction

    function void note_item(logic [7:0] b, logic present, logic last);
        int count_prior;
        count_prior = pending.size();
        if (present)
        begin
            if (fill == 3)
            begin
                put_group({grp, b});
                grp = '0;
                fill = 0;
            end
            else
            begin
                grp = {grp[15:0], b};
                fill++;
            end
        end
        if (last)
        begin
            put_flush();
            clear();
        end
        if (pending.size() > count_prior)
            pending[$][8] = 1'b1;
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_char(logic [7:0] c, logic run_end);
        logic [8:0] exp_ch;
        if (pending.size() == 0)
        begin
            report($sformatf("unexpected char %02h", c));
            return;
        end
        exp_ch = pending.pop_front();
        if (c !== exp_ch[7:0])
            report($sformatf("out_char %02h, expected %02h", c, exp_ch[7:0]));
        if (run_end !== exp_ch[8])
            report($sformatf("run_end %b, expected %b", run_end, exp_ch[8]));
    endtask
endclass

module tb_ascii85_line_encoder;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int cycles = 0;
    bit calm = 0;
    a85_scoreboard board;

    a85_item_if items();
    a85_char_if chars();
    a85_cfg_if cfg();

    ascii85_line_encoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items.sink),
        .chars(chars.source),
        .cfg(cfg.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        items.valid = 1'b0;
        items.data_byte = '0;
        items.byte_present = 1'b0;
        items.is_last = 1'b0;
        chars.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.col_limit = '0;
        board = new();
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // sink side: random stalls, check on each transaction
    always @(posedge clk)
        if (rst_n && chars.valid && chars.ready)
            board.check_char(chars.out_char, chars.run_end);

    always @(negedge clk)
        chars.ready <= calm || ($urandom_range(0, 99) >= 13);

    // hold valid across back-to-back transactions, drop it only to idle
    task send_item(logic [7:0] b, logic present, logic last);
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            items.valid <= 1'b0;
            @(negedge clk);
        end
        items.valid <= 1'b1;
        items.data_byte <= b;
        items.byte_present <= present;
        items.is_last <= last;
        do
            @(posedge clk);
        while (!items.ready);
        board.note_item(b, present, last);
        @(negedge clk);
    endtask

    task drain();
        items.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task write_limit(logic [7:0] value);
        cfg.valid <= 1'b1;
        cfg.col_limit <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        board.limit = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task random_stream(int count);
        logic [7:0] b;
        int mode;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 3)
                b = 8'h00;
            else if (mode < 5)
                b = 8'(8'h0e + $urandom_range(0, 3));
            else
                b = 8'($urandom);
            send_item(b, $urandom_range(0, 19) != 0, 1'b0);
        end
        send_item(8'($urandom), 1'($urandom), 1'b1);
    endtask

    initial
    begin
        logic [7:0] limits[4];
        limits = '{a85_tb_pkg::LIMIT_MIN, a85_tb_pkg::LIMIT_MAX, 8'd13,
                   a85_pkg::LIMIT_RESET};
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero group, all-ones group, percent-start groups, flushes
        send_item(8'h00, 1, 0); send_item(8'h00, 1, 0);
        send_item(8'h00, 1, 0); send_item(8'h00, 1, 0);
        send_item(8'hff, 1, 0); send_item(8'hff, 1, 0);
        send_item(8'hff, 1, 0); send_item(8'hff, 1, 0);
        send_item(8'h00, 0, 1);
        // percent at line start: word near 4*85^4
        send_item(8'h0f, 1, 0); send_item(8'h5a, 1, 0);
        send_item(8'h08, 1, 0); send_item(8'h44, 1, 0);
        send_item(8'h0f, 1, 0); send_item(8'h5a, 1, 1);
        send_item(8'h0e, 1, 0); send_item(8'h00, 1, 0);
        send_item(8'h00, 1, 1);
        send_item(8'h0e, 1, 1);
        send_item(8'h00, 0, 1);
        send_item(8'h00, 0, 0);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_limit(limits[p]);
            calm = (p == 1);
            random_stream(60);
            drain();
        end
        calm = 0;

        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

// File: sim.f
rtl/core/a85_pkg.sv
rtl/core/a85_if.sv
rtl/core/a85_front.sv
rtl/core/a85_queue.sv
rtl/core/a85_digits.sv
rtl/core/a85_emit.sv
rtl/core/ascii85_line_encoder.sv
sim/a85_tb_if.sv
sim/tb_ascii85_line_encoder.sv
